@@ hdl/tsp_pkg.sv @@
// shared constants, types and helper functions for the time text parser
`default_nettype none

package tsp_pkg;

    // text length limit and kept fraction digits
    localparam int MaxLen     = 16;
    localparam int FracDigits = 6;
    localparam int KeepDigits = (FracDigits < 6) ? FracDigits : 6;

    // character codes
    localparam logic [7:0] CharZero   = 8'h30;
    localparam logic [7:0] CharNine   = 8'h39;
    localparam logic [7:0] CharPeriod = 8'h2E;
    localparam logic [7:0] CharColon  = 8'h3A;

    // zone offset limits in minutes
    localparam logic signed [10:0] ZoneMin = -11'sd720;
    localparam logic signed [10:0] ZoneMax = 11'sd840;

    // configuration register indexes
    localparam logic CfgAcceptLegacy = 1'b0;
    localparam logic CfgZoneOffset   = 1'b1;

    // packed widths of the streams
    localparam int InDataW  = 8;
    localparam int OutDataW = 56;

    // form tracking flags
    typedef struct packed {
        logic too_long;
        logic colon_dead;
        logic plain_dead;
    } form_flags_t;

    // finished text waiting for the result stage
    typedef struct packed {
        logic [5:0]         length;
        form_flags_t        flags;
        logic [6:0]         hour;
        logic [6:0]         minute;
        logic [6:0]         second;
        logic [19:0]        frac;
        logic [2:0]         frac_count;
        logic               legacy;
        logic signed [10:0] zone;
    } text_snap_t;

    // value times ten plus one decimal digit, modulo 2^20
    function automatic logic [19:0] mul10_add(input logic [19:0] v, input logic [3:0] d);
        mul10_add = (v << 3) + (v << 1) + {16'b0, d};
    endfunction

    // scale of kept fraction digits to microseconds
    function automatic logic [19:0] frac_scale(input logic [2:0] cnt);
        logic [19:0] s;
        case (cnt)
            3'd0:    s = 20'd1000000;
            3'd1:    s = 20'd100000;
            3'd2:    s = 20'd10000;
            3'd3:    s = 20'd1000;
            3'd4:    s = 20'd100;
            3'd5:    s = 20'd10;
            default: s = 20'd1;
        endcase
        frac_scale = s;
    endfunction

endpackage

`default_nettype wire

@@ hdl/time_string_parser.sv @@
// time text parser: one character per request, one result per text
//
// Usage: characters arrive on the s_axis channel, one per request, with
// s_axis_tlast on the final character of a text. Each character updates a
// small set of field accumulators in the cycle it is accepted. On the final
// character the finished fields are captured in a hand-off register and the
// accumulators clear, so the next character starts a new text at once.
// The result stage scales the fraction (one 20 x 20 bit multiply) and checks
// the ranges, then places one result on m_axis.
// Throughput: one character per cycle while s_axis_tready is high, set by the
// accumulator update on each accepted character. A result passes through the
// hand-off register and then the output register before it appears on m_axis.
// Stall: when m_axis_tready is low the result holds in the output register;
// one more finished text may wait in the hand-off register, and once that
// register is occupied as well s_axis_tready drops until the result is taken.
// Reset (rst_n low, asynchronous) clears the text state and both stages,
// sets accept_legacy to 1 and the zone offset to 0.
// Configuration: cfg_we writes register cfg_index with cfg_data at once.
`default_nettype none

module time_string_parser
    import tsp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration write port
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [10:0]         cfg_data,
    // character input
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [InDataW-1:0]  s_axis_tdata,   // [7:0] text_char
    input  wire logic                s_axis_tlast,   // is_last
    // result output
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [OutDataW-1:0]      m_axis_tdata    // [0] valid_res, [5:1] hour,
                                                     // [11:6] minute, [17:12] second,
                                                     // [37:18] microseconds,
                                                     // [38] used_legacy,
                                                     // [49:39] zone_minutes,
                                                     // [55:50] zero
);

    // configuration registers
    logic               legacy_reg;
    logic signed [10:0] zone_reg;

    // text state
    logic [4:0]  pos_reg,        pos_next;
    form_flags_t flags_reg,      flags_next;
    logic [6:0]  hour_reg,       hour_next;
    logic [6:0]  minute_reg,     minute_next;
    logic [6:0]  second_reg,     second_next;
    logic [19:0] frac_reg,       frac_next;
    logic [2:0]  frac_cnt_reg,   frac_cnt_next;

    // hand-off and output stages
    text_snap_t            snap_reg,  snap_next;
    logic                  snap_valid_reg, snap_valid_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [OutDataW-1:0]   out_data_reg,   out_data_next;

    logic       s_fire;
    logic       out_load;
    logic [7:0] ch;
    logic       is_digit;
    logic [3:0] digit;
    logic       plain_match;
    logic       colon_match;
    logic       plain_alive;
    logic       colon_alive;
    logic       take_frac;

    logic [5:0]  r_len;
    logic        r_plain_ok;
    logic        r_colon_ok;
    logic        r_ok;
    logic [19:0] r_product;

    assign ch            = s_axis_tdata[7:0];
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !snap_valid_reg || out_load;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            legacy_reg <= 1'b1;
            zone_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgAcceptLegacy: legacy_reg <= cfg_data[0];
                CfgZoneOffset:   zone_reg   <= cfg_data;
                default:         legacy_reg <= legacy_reg;
            endcase
        end
    end

    // character classification against the expected form
    always_comb
    begin
        is_digit = (ch >= CharZero) && (ch <= CharNine);
        digit    = is_digit ? 4'(ch - CharZero) : 4'd0;

        if (pos_reg == 5'd6)
            plain_match = (ch == CharPeriod);
        else
            plain_match = is_digit;

        if (pos_reg == 5'd2 || pos_reg == 5'd5)
            colon_match = (ch == CharColon);
        else if (pos_reg == 5'd8)
            colon_match = (ch == CharPeriod);
        else
            colon_match = is_digit;
    end

    // accumulator update for one character
    always_comb
    begin
        flags_next    = flags_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        frac_next     = frac_reg;
        frac_cnt_next = frac_cnt_reg;
        take_frac     = 1'b0;

        if (pos_reg >= 5'(MaxLen))
            flags_next.too_long = 1'b1;
        if (!plain_match)
            flags_next.plain_dead = 1'b1;
        if (!colon_match)
            flags_next.colon_dead = 1'b1;

        plain_alive = !flags_next.plain_dead;
        colon_alive = !flags_next.colon_dead;

        if (is_digit)
        begin
            if (pos_reg <= 5'd1)
                hour_next = 7'(mul10_add({13'b0, hour_reg}, digit));
            else if ((plain_alive && (pos_reg == 5'd2 || pos_reg == 5'd3)) ||
                     (colon_alive && (pos_reg == 5'd3 || pos_reg == 5'd4)))
                minute_next = 7'(mul10_add({13'b0, minute_reg}, digit));
            else if ((plain_alive && (pos_reg == 5'd4 || pos_reg == 5'd5)) ||
                     (colon_alive && (pos_reg == 5'd6 || pos_reg == 5'd7)))
                second_next = 7'(mul10_add({13'b0, second_reg}, digit));
            else if ((plain_alive && pos_reg >= 5'd7) || (colon_alive && pos_reg >= 5'd9))
                take_frac = 1'b1;
        end

        if (take_frac && (frac_cnt_reg < 3'(KeepDigits)))
        begin
            frac_next     = mul10_add(frac_reg, digit);
            frac_cnt_next = frac_cnt_reg + 3'd1;
        end

        pos_next = (pos_reg < 5'd31) ? pos_reg + 5'd1 : pos_reg;
    end

    // finished text captured for the result stage
    always_comb
    begin
        snap_next.length     = {1'b0, pos_reg} + 6'd1;
        snap_next.flags      = flags_next;
        snap_next.hour       = hour_next;
        snap_next.minute     = minute_next;
        snap_next.second     = second_next;
        snap_next.frac       = frac_next;
        snap_next.frac_count = frac_cnt_next;
        snap_next.legacy     = legacy_reg;
        snap_next.zone       = zone_reg;

        if (s_fire && s_axis_tlast)
            snap_valid_next = 1'b1;
        else if (out_load)
            snap_valid_next = 1'b0;
        else
            snap_valid_next = snap_valid_reg;
    end

    // text state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            flags_reg    <= '0;
            hour_reg     <= '0;
            minute_reg   <= '0;
            second_reg   <= '0;
            frac_reg     <= '0;
            frac_cnt_reg <= '0;
        end
        else if (s_fire)
        begin
            if (s_axis_tlast)
            begin
                pos_reg      <= '0;
                flags_reg    <= '0;
                hour_reg     <= '0;
                minute_reg   <= '0;
                second_reg   <= '0;
                frac_reg     <= '0;
                frac_cnt_reg <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                flags_reg    <= flags_next;
                hour_reg     <= hour_next;
                minute_reg   <= minute_next;
                second_reg   <= second_next;
                frac_reg     <= frac_next;
                frac_cnt_reg <= frac_cnt_next;
            end
        end
    end

    // hand-off register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else
            snap_valid_reg <= snap_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && s_axis_tlast)
            snap_reg <= snap_next;
    end

    // form and range checks, fraction scaling
    always_comb
    begin
        r_len      = snap_reg.length;
        r_plain_ok = !snap_reg.flags.plain_dead &&
                     (r_len == 6'd2 || r_len == 6'd4 || r_len == 6'd6 || r_len >= 6'd8);
        r_colon_ok = snap_reg.legacy && !snap_reg.flags.colon_dead &&
                     (r_len == 6'd5 || r_len == 6'd8 || r_len >= 6'd10);
        r_ok       = (r_plain_ok || r_colon_ok) && !snap_reg.flags.too_long &&
                     (snap_reg.hour < 7'd24) && (snap_reg.minute < 7'd60) &&
                     (snap_reg.second < 7'd60) &&
                     (snap_reg.zone >= ZoneMin) && (snap_reg.zone <= ZoneMax);
        r_product  = snap_reg.frac * frac_scale(snap_reg.frac_count);

        out_data_next = '0;
        if (r_ok)
        begin
            out_data_next[0]     = 1'b1;
            out_data_next[5:1]   = snap_reg.hour[4:0];
            out_data_next[11:6]  = snap_reg.minute[5:0];
            out_data_next[17:12] = snap_reg.second[5:0];
            out_data_next[37:18] = r_product;
            out_data_next[38]    = r_colon_ok && !r_plain_ok;
            out_data_next[49:39] = snap_reg.zone;
        end

        if (out_load)
            out_valid_next = snap_valid_reg;
        else
            out_valid_next = out_valid_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && snap_valid_reg)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    // a final character clears the text state and fills the hand-off register
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_axis_tlast |=> pos_reg == 5'd0 && snap_valid_reg)
        else $error("final character did not clear text state");

    // a waiting finished text is kept while the output stalls
    a_snap_holds: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid_reg && !out_load |=> snap_valid_reg && $stable(snap_reg))
        else $error("finished text lost during output stall");

    // input is only held back when the hand-off register is occupied
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> snap_valid_reg && out_valid_reg)
        else $error("input stalled without a waiting result");

    // a failed text carries all-zero fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata == '0)
        else $error("invalid result with non-zero fields");

    // a good result is within the legal time ranges
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            m_axis_tdata[5:1] < 5'd24 && m_axis_tdata[11:6] < 6'd60 &&
            m_axis_tdata[17:12] < 6'd60)
        else $error("valid result out of range");
`endif

endmodule

`default_nettype wire
